### sv/gtc_pkg.sv
package gtc_pkg;

    // Largest millivolt value a channel or baseline may carry after clamping
    localparam int unsigned VOLT_MAX_MV = 5000;

    localparam int unsigned MV_W   = 13;
    localparam int unsigned CONF_W = 7;

    // Gas class codes
    localparam logic [1:0] GAS_CLEAR   = 2'd0;
    localparam logic [1:0] GAS_LPG     = 2'd1;
    localparam logic [1:0] GAS_METHANE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CALIBRATED   = 3'd0;
    localparam logic [2:0] CFG_BASE_LPG_A   = 3'd1;
    localparam logic [2:0] CFG_BASE_LPG_B   = 3'd2;
    localparam logic [2:0] CFG_BASE_LPG_C   = 3'd3;
    localparam logic [2:0] CFG_BASE_METHANE = 3'd4;
    localparam logic [2:0] CFG_DETECT_DELTA = 3'd5;
    localparam logic [2:0] CFG_FULLSCALE    = 3'd6;

    localparam logic [CONF_W-1:0] CONF_FULL = 7'd100;
    localparam logic [CONF_W-1:0] CONF_MIN  = 7'd1;

    typedef struct packed {
        logic [MV_W-1:0] volt_lpg_a;
        logic [MV_W-1:0] volt_lpg_b;
        logic [MV_W-1:0] volt_lpg_c;
        logic [MV_W-1:0] volt_methane;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        gas_class;
        logic [CONF_W-1:0] confidence;
    } t_out_item;

endpackage

### sv/gas_threshold_classifier.sv
// Throughput: one item per cycle while the output is not stalled; an 8-stage
// pipeline whose last four stages hold the confidence divider, two quotient
// bits per stage (one in the last).
// A stalled output holds only the stages behind it that are full.
// Reset (synchronous, active low) empties the pipeline and clears all
// configuration registers to 0.
module gas_threshold_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gtc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gtc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data
);
    import gtc_pkg::*;

    localparam int unsigned NSTG  = 8;
    localparam int unsigned REM_W = 20;
    localparam logic [16:0] VOLT_MAX_W = 17'(VOLT_MAX_MV);

    typedef struct packed {
        logic [1:0]        gas;
        logic              force_full;
        logic [REM_W-1:0]  rem;
        logic [CONF_W-1:0] quo;
    } t_div;

    // Clamp a millivolt value to the supply limit
    function automatic logic [MV_W-1:0] sat_mv(input logic [MV_W-1:0] v);
        if ({4'b0, v} > VOLT_MAX_W)
            return VOLT_MAX_W[MV_W-1:0];
        return v;
    endfunction

    // One restoring division step producing quotient bit k
    function automatic t_div div_step(input t_div d, input logic [MV_W-1:0] fs,
                                      input logic [2:0] k);
        logic [REM_W-1:0] sh;
        t_div             o;
        sh = REM_W'(fs) << k;
        o  = d;
        if (d.rem >= sh) begin
            o.rem    = d.rem - sh;
            o.quo[k] = 1'b1;
        end
        return o;
    endfunction

    // Configuration registers
    logic            r_calibrated;
    logic [MV_W-1:0] r_base [4];
    logic [MV_W-1:0] r_detect;
    logic [MV_W-1:0] r_fullscale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrated <= 1'b0;
            r_base[0]    <= '0;
            r_base[1]    <= '0;
            r_base[2]    <= '0;
            r_base[3]    <= '0;
            r_detect     <= '0;
            r_fullscale  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CALIBRATED:   r_calibrated <= i_cfg_data[0];
                CFG_BASE_LPG_A:   r_base[0]    <= i_cfg_data;
                CFG_BASE_LPG_B:   r_base[1]    <= i_cfg_data;
                CFG_BASE_LPG_C:   r_base[2]    <= i_cfg_data;
                CFG_BASE_METHANE: r_base[3]    <= i_cfg_data;
                CFG_DETECT_DELTA: r_detect     <= i_cfg_data;
                CFG_FULLSCALE:    r_fullscale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
            stg_en[k] = !r_vld[k] || stg_en[k+1];
    end

    assign o_in_ready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0])
                r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++)
                if (stg_en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage 0: clamp voltages, form detect thresholds
    logic [MV_W-1:0] in_volt [4];
    logic [MV_W-1:0] r0_volt [4];
    logic [MV_W:0]   r0_thr  [4];

    assign in_volt[0] = i_in_data.volt_lpg_a;
    assign in_volt[1] = i_in_data.volt_lpg_b;
    assign in_volt[2] = i_in_data.volt_lpg_c;
    assign in_volt[3] = i_in_data.volt_methane;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            for (int c = 0; c < 4; c++) begin
                r0_volt[c] <= sat_mv(in_volt[c]);
                r0_thr[c]  <= {1'b0, sat_mv(r_base[c])} + {1'b0, r_detect};
            end
        end
    end

    // Stage 1: positive excess over threshold per channel
    logic [MV_W-1:0] r1_exc [4];
    logic [MV_W:0]   n1_diff [4];

    always_comb begin
        for (int c = 0; c < 4; c++)
            n1_diff[c] = {1'b0, r0_volt[c]} - r0_thr[c];
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            for (int c = 0; c < 4; c++)
                r1_exc[c] <= ({1'b0, r0_volt[c]} > r0_thr[c]) ? n1_diff[c][MV_W-1:0] : '0;
        end
    end

    // Stage 2: largest excess within each group
    logic [MV_W-1:0] r2_lpg;
    logic [MV_W-1:0] r2_meth;
    logic [MV_W-1:0] n2_ab;

    assign n2_ab = (r1_exc[1] > r1_exc[0]) ? r1_exc[1] : r1_exc[0];

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r2_lpg  <= (r1_exc[2] > n2_ab) ? r1_exc[2] : n2_ab;
            r2_meth <= r1_exc[3];
        end
    end

    // Stage 3: pick the winning group, scale excess by 100 for the divider
    t_div            r_div [3:6];
    t_div            n3_div;
    logic [MV_W-1:0] n3_exc;
    logic            n3_none;

    always_comb begin
        n3_none = !r_calibrated || (r2_lpg == '0 && r2_meth == '0);
        if (r2_lpg >= r2_meth) begin
            n3_div.gas = GAS_LPG;
            n3_exc     = r2_lpg;
        end else begin
            n3_div.gas = GAS_METHANE;
            n3_exc     = r2_meth;
        end
        if (n3_none)
            n3_div.gas = GAS_CLEAR;
        // At or beyond the span the quotient is at least 100: saturate
        n3_div.force_full = n3_none || r_fullscale == '0 || n3_exc >= r_fullscale;
        n3_div.rem        = REM_W'(n3_exc) * REM_W'(CONF_FULL);
        n3_div.quo        = '0;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3])
            r_div[3] <= n3_div;
    end

    // Stages 4 to 6: two quotient bits each
    always_ff @(posedge i_clk) begin
        if (stg_en[4])
            r_div[4] <= div_step(div_step(r_div[3], r_fullscale, 3'd6), r_fullscale, 3'd5);
        if (stg_en[5])
            r_div[5] <= div_step(div_step(r_div[4], r_fullscale, 3'd4), r_fullscale, 3'd3);
        if (stg_en[6])
            r_div[6] <= div_step(div_step(r_div[5], r_fullscale, 3'd2), r_fullscale, 3'd1);
    end

    // Stage 7: last quotient bit, clamp and output register
    t_div      n7_div;
    t_out_item r_out;

    assign n7_div = div_step(r_div[6], r_fullscale, 3'd0);

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r_out.gas_class <= n7_div.gas;
            if (n7_div.force_full)
                r_out.confidence <= CONF_FULL;
            else if (n7_div.quo == '0)
                r_out.confidence <= CONF_MIN;
            else
                r_out.confidence <= n7_div.quo;
        end
    end

    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.confidence >= CONF_MIN &&
                         o_out_data.confidence <= CONF_FULL))
        else $error("confidence out of range");

    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.gas_class == GAS_CLEAR) |->
            o_out_data.confidence == CONF_FULL)
        else $error("clear result without full confidence");

    a_uncal_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_calibrated) |-> o_out_data.gas_class == GAS_CLEAR)
        else $error("detection reported while not calibrated");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.gas_class == GAS_CLEAR ||
                         o_out_data.gas_class == GAS_LPG ||
                         o_out_data.gas_class == GAS_METHANE))
        else $error("invalid gas class code");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG-1] |-> o_in_ready)
        else $error("input stalled with empty output stage");
`endif

endmodule

### sim/gas_threshold_classifier_test.sv
module gas_threshold_classifier_test;
    import gtc_pkg::*;

    localparam int unsigned MV_ALL_ONES = 8191;

    // Mirror of the register file plus the queue of classifications still owed
    class verdict_tracker;
        logic            calib;
        logic [MV_W-1:0] base_mv [4];
        logic [MV_W-1:0] det_mv;
        logic [MV_W-1:0] span_mv;
        t_out_item       awaited [$];
        int unsigned     failures;
        int unsigned     n_clear;
        int unsigned     n_lpg;
        int unsigned     n_methane;

        function new();
            calib = 1'b0;
            foreach (base_mv[i]) base_mv[i] = '0;
            det_mv    = '0;
            span_mv   = '0;
            failures  = 0;
            n_clear   = 0;
            n_lpg     = 0;
            n_methane = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [MV_W-1:0] data);
            case (idx)
                CFG_CALIBRATED:   calib = data[0];
                CFG_BASE_LPG_A:   base_mv[0] = data;
                CFG_BASE_LPG_B:   base_mv[1] = data;
                CFG_BASE_LPG_C:   base_mv[2] = data;
                CFG_BASE_METHANE: base_mv[3] = data;
                CFG_DETECT_DELTA: det_mv = data;
                CFG_FULLSCALE:    span_mv = data;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_mv(logic [MV_W-1:0] v);
            return (v > VOLT_MAX_MV) ? VOLT_MAX_MV : int'(v);
        endfunction

        // Detect threshold of a channel: 0..2 LPG, 3 methane
        function int unsigned threshold(int ch);
            return clamp_mv(base_mv[ch]) + det_mv;
        endfunction

        function int unsigned excess_over(int ch, logic [MV_W-1:0] volt);
            int unsigned v;
            int unsigned thr;
            v   = clamp_mv(volt);
            thr = threshold(ch);
            return (v > thr) ? v - thr : 0;
        endfunction

        function t_out_item classify(t_in_item s);
            int unsigned lpg_best;
            int unsigned meth_best;
            int unsigned win;
            int unsigned pct;
            t_out_item   r;
            r.gas_class  = GAS_CLEAR;
            r.confidence = CONF_FULL;
            if (!calib) return r;
            // Largest excess within the LPG group, then the single methane channel
            lpg_best = excess_over(0, s.volt_lpg_a);
            if (excess_over(1, s.volt_lpg_b) > lpg_best) lpg_best = excess_over(1, s.volt_lpg_b);
            if (excess_over(2, s.volt_lpg_c) > lpg_best) lpg_best = excess_over(2, s.volt_lpg_c);
            meth_best = excess_over(3, s.volt_methane);
            if (lpg_best == 0 && meth_best == 0) return r;
            // LPG takes the tie
            if (lpg_best >= meth_best) begin
                r.gas_class = GAS_LPG;
                win = lpg_best;
            end else begin
                r.gas_class = GAS_METHANE;
                win = meth_best;
            end
            if (span_mv == 0) begin
                pct = 100;
            end else begin
                pct = (win * 100) / span_mv;
                if (pct > 100) pct = 100;
                if (pct < 1) pct = 1;
            end
            r.confidence = pct[CONF_W-1:0];
            return r;
        endfunction

        function void note_sample(t_in_item s);
            t_out_item v;
            v = classify(s);
            awaited.push_back(v);
            case (v.gas_class)
                GAS_LPG:     n_lpg++;
                GAS_METHANE: n_methane++;
                default:     n_clear++;
            endcase
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                $error("result with no sample set waiting: gas_class %0d confidence %0d",
                       got.gas_class, got.confidence);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.gas_class !== want.gas_class) begin
                $error("gas_class: expected %0d, actual %0d", want.gas_class, got.gas_class);
                failures++;
            end
            if (got.confidence !== want.confidence) begin
                $error("confidence: expected %0d, actual %0d", want.confidence, got.confidence);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = CFG_CALIBRATED;
    logic [MV_W-1:0]   i_cfg_data = '0;

    verdict_tracker    sb;
    int unsigned       send_idle_pct = 29;
    int unsigned       recv_idle_pct = 75;
    int unsigned       n_settings = 0;

    gas_threshold_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check each result transfer, then decide whether to stall the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_verdict(o_out_data);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one sample set after a random gap and hold it until the transfer
    task automatic transfer_sample(t_in_item s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(s);
    endtask

    task automatic send_set(int unsigned a, int unsigned b, int unsigned c, int unsigned m);
        t_in_item s;
        s.volt_lpg_a   = a[MV_W-1:0];
        s.volt_lpg_b   = b[MV_W-1:0];
        s.volt_lpg_c   = c[MV_W-1:0];
        s.volt_methane = m[MV_W-1:0];
        transfer_sample(s);
    endtask

    task automatic cfg_write(logic [2:0] idx, int unsigned data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[MV_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data[MV_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(bit cal, int unsigned ba, int unsigned bb, int unsigned bc,
                                 int unsigned bm, int unsigned det, int unsigned span);
        cfg_write(CFG_CALIBRATED, cal);
        cfg_write(CFG_BASE_LPG_A, ba);
        cfg_write(CFG_BASE_LPG_B, bb);
        cfg_write(CFG_BASE_LPG_C, bc);
        cfg_write(CFG_BASE_METHANE, bm);
        cfg_write(CFG_DETECT_DELTA, det);
        cfg_write(CFG_FULLSCALE, span);
        n_settings++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline run dry
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic int unsigned rand_mv(int unsigned in_range_pct);
        return ($urandom_range(99) < in_range_pct) ? $urandom_range(VOLT_MAX_MV)
                                                   : $urandom_range(MV_ALL_ONES);
    endfunction

    // Voltage biased around a channel threshold, with some noise across the field
    function automatic int unsigned pick_volt(int unsigned thr, int unsigned span);
        int unsigned reach;
        int unsigned v;
        reach = (span > 40) ? span + span / 4 : 50;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(MV_ALL_ONES);
            3, 4:    v = $urandom_range(VOLT_MAX_MV);
            5:       v = thr;
            6:       v = (thr > reach) ? thr - $urandom_range(reach) : $urandom_range(thr);
            default: v = thr + $urandom_range(reach);
        endcase
        return (v > MV_ALL_ONES) ? MV_ALL_ONES : v;
    endfunction

    initial begin
        int unsigned pick [4];
        int unsigned det;
        int unsigned span;
        int unsigned sel;

        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state is uncalibrated: everything reads clear
        send_set(5000, 5000, 5000, 5000);
        send_set(0, 0, 0, MV_ALL_ONES);

        // Thresholds 1100 / 1300 / 1500 / 1700, span 400
        settle();
        apply_setting(1'b1, 1000, 1200, 1400, 1600, 100, 400);
        send_set(0, 0, 0, 0);
        send_set(1100, 1300, 1500, 1700);
        send_set(1101, 0, 0, 0);
        send_set(1104, 0, 0, 0);
        send_set(1500, 0, 0, 0);
        send_set(5000, 0, 0, 0);
        send_set(0, 1400, 0, 0);
        send_set(0, 0, 1700, 0);
        send_set(0, 0, 0, 1800);
        send_set(1200, 0, 0, 1800);
        send_set(1150, 0, 0, 1900);
        send_set(MV_ALL_ONES, MV_ALL_ONES, MV_ALL_ONES, MV_ALL_ONES);
        send_set(13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA);
        send_set(13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555);
        send_set(0, 0, 0, MV_ALL_ONES);

        // Zero span forces full confidence
        settle();
        cfg_write(CFG_FULLSCALE, 0);
        send_set(1101, 0, 0, 0);
        send_set(0, 0, 0, 5000);

        // Baselines and delta at the top of the field: nothing can exceed
        settle();
        apply_setting(1'b1, MV_ALL_ONES, MV_ALL_ONES, MV_ALL_ONES, MV_ALL_ONES,
                      MV_ALL_ONES, MV_ALL_ONES);
        send_set(MV_ALL_ONES, MV_ALL_ONES, MV_ALL_ONES, MV_ALL_ONES);

        // Zero baselines and delta with the widest span
        settle();
        apply_setting(1'b1, 0, 0, 0, 0, 0, MV_ALL_ONES);
        send_set(MV_ALL_ONES, 0, 0, 0);
        send_set(0, 0, 0, 1);

        // Random settings, three per idling pattern
        for (int ph = 0; ph < 9; ph++) begin
            settle();
            case (ph / 3)
                0: begin send_idle_pct = 29; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sel = $urandom_range(9);
            det = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(400) : $urandom_range(MV_ALL_ONES);
            sel = $urandom_range(9);
            span = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(1000, 1)
                                              : $urandom_range(MV_ALL_ONES);
            apply_setting((ph == 5) ? 1'b0 : 1'b1, rand_mv(80), rand_mv(80), rand_mv(80),
                          rand_mv(80), det, span);
            repeat (190) begin
                for (int ch = 0; ch < 4; ch++) pick[ch] = pick_volt(sb.threshold(ch), span);
                // Now and then mirror the first LPG excess onto methane to provoke a tie
                if ($urandom_range(9) == 0 && pick[0] > sb.threshold(0))
                    pick[3] = sb.threshold(3) + pick[0] - sb.threshold(0);
                if (pick[3] > MV_ALL_ONES) pick[3] = MV_ALL_ONES;
                send_set(pick[0], pick[1], pick[2], pick[3]);
            end
        end

        settle();
        $display("Covered %0d sample sets over %0d register settings with three idling patterns.",
                 sb.n_clear + sb.n_lpg + sb.n_methane, n_settings);
        $display("Verdicts: %0d clear, %0d LPG, %0d methane; %0d mismatches.",
                 sb.n_clear, sb.n_lpg, sb.n_methane, sb.failures);
        if (sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #3000000;
        $display("timeout with %0d results still owed", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
